// ===== sv/fraction_lowest_terms_defines.svh =====
`ifndef FRACTION_LOWEST_TERMS_DEFINES_SVH
`define FRACTION_LOWEST_TERMS_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define FLT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check that cons holds in the cycle after ante
`define FLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/flt_pkg.sv =====
`timescale 1ns / 1ps

package flt_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_QN,
    S_QD,
    S_DONE
  } state_t;

endpackage

// ===== sv/fraction_lowest_terms.sv =====
// Fraction reduction to lowest terms.
// Input channel: numer_in, denom_in with in_valid / in_stall. A word is taken
// when in_valid is high and in_stall is low. Output channel: numer_out,
// denom_out, common_div, is_whole, div_error with out_valid / out_stall.
// One shared restoring divider, one quotient bit per cycle, runs every step:
// each remainder step of Euclid's rule, then numerator / divisor, then
// denominator / divisor. The number of remainder steps Euclid's rule needs
// depends on the pair (1 up to about 46 at 32 bits). A zero denominator
// raises out_valid with div_error in the cycle after accept, with all
// other fields zero.
// One word at a time: in_stall stays high from accept until the result word
// is taken. While out_stall is high the result word holds unchanged.
// Reset returns the sequencer to idle, drops any word in flight and clears
// out_valid; nothing else needs clearing.
`timescale 1ns / 1ps
`include "fraction_lowest_terms_defines.svh"

module fraction_lowest_terms #(
  parameter int DATA_WIDTH = flt_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] numer_in,
  input  logic [DATA_WIDTH-1:0] denom_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] numer_out,
  output logic [DATA_WIDTH-1:0] denom_out,
  output logic [DATA_WIDTH-1:0] common_div,
  output logic                  is_whole,
  output logic                  div_error
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  flt_pkg::state_t state, state_next;

  logic [W-1:0]  numer, numer_next;
  logic [W-1:0]  denom, denom_next;
  logic [W-1:0]  rem, rem_next;
  logic [W-1:0]  quo, quo_next;
  logic [W-1:0]  dvsr, dvsr_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [W-1:0]  res_numer, res_numer_next;
  logic [W-1:0]  res_denom, res_denom_next;
  logic [W-1:0]  res_gcd, res_gcd_next;
  logic          res_whole, res_whole_next;
  logic          res_error, res_error_next;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  quo_step;
  logic          last;
  logic          dividing;
  logic          fields_clear;

  assign trial    = {rem, quo[W-1]};
  assign diff     = trial - {1'b0, dvsr};
  assign ge       = trial >= {1'b0, dvsr};
  assign rem_step = ge ? diff[W-1:0] : trial[W-1:0];
  assign quo_step = {quo[W-2:0], ge};
  assign last     = cnt == CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    numer     <= numer_next;
    denom     <= denom_next;
    rem       <= rem_next;
    quo       <= quo_next;
    dvsr      <= dvsr_next;
    cnt       <= cnt_next;
    res_numer <= res_numer_next;
    res_denom <= res_denom_next;
    res_gcd   <= res_gcd_next;
    res_whole <= res_whole_next;
    res_error <= res_error_next;
  end

  always_comb begin
    state_next     = state;
    numer_next     = numer;
    denom_next     = denom;
    rem_next       = rem;
    quo_next       = quo;
    dvsr_next      = dvsr;
    cnt_next       = cnt;
    res_numer_next = res_numer;
    res_denom_next = res_denom;
    res_gcd_next   = res_gcd;
    res_whole_next = res_whole;
    res_error_next = res_error;
    unique case (state)
      flt_pkg::S_IDLE: begin
        if (in_valid) begin
          numer_next = numer_in;
          denom_next = denom_in;
          rem_next   = '0;
          quo_next   = numer_in;
          dvsr_next  = denom_in;
          cnt_next   = CW'(W);
          if (denom_in == '0) begin
            res_numer_next = '0;
            res_denom_next = '0;
            res_gcd_next   = '0;
            res_whole_next = 1'b0;
            res_error_next = 1'b1;
            state_next     = flt_pkg::S_DONE;
          end else begin
            state_next = flt_pkg::S_GCD;
          end
        end
      end
      flt_pkg::S_GCD: begin
        rem_next = rem_step;
        quo_next = quo_step;
        cnt_next = cnt - 1'b1;
        if (last) begin
          rem_next = '0;
          cnt_next = CW'(W);
          if (rem_step == '0) begin
            res_gcd_next = dvsr;
            quo_next     = numer;
            state_next   = flt_pkg::S_QN;
          end else begin
            quo_next  = dvsr;
            dvsr_next = rem_step;
          end
        end
      end
      flt_pkg::S_QN: begin
        rem_next = rem_step;
        quo_next = quo_step;
        cnt_next = cnt - 1'b1;
        if (last) begin
          res_numer_next = quo_step;
          rem_next       = '0;
          quo_next       = denom;
          cnt_next       = CW'(W);
          state_next     = flt_pkg::S_QD;
        end
      end
      flt_pkg::S_QD: begin
        rem_next = rem_step;
        quo_next = quo_step;
        cnt_next = cnt - 1'b1;
        if (last) begin
          res_denom_next = quo_step;
          res_whole_next = quo_step == W'(1);
          res_error_next = 1'b0;
          state_next     = flt_pkg::S_DONE;
        end
      end
      flt_pkg::S_DONE: begin
        if (!out_stall) begin
          state_next = flt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = flt_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall   = state != flt_pkg::S_IDLE;
  assign out_valid  = state == flt_pkg::S_DONE;
  assign numer_out  = res_numer;
  assign denom_out  = res_denom;
  assign common_div = res_gcd;
  assign is_whole   = res_whole;
  assign div_error  = res_error;

  assign dividing     = state == flt_pkg::S_GCD || state == flt_pkg::S_QN ||
                        state == flt_pkg::S_QD;
  assign fields_clear = numer_out == '0 && denom_out == '0 && common_div == '0 &&
                        !is_whole;

  `FLT_ASSERT_SAME(a_busy_while_out, out_valid, in_stall, "input open while result pending")
  `FLT_ASSERT_SAME(a_div_nonzero, dividing, dvsr != '0, "divide by zero in shared divider")
  `FLT_ASSERT_SAME(a_error_zero, out_valid && div_error, fields_clear, "error word not clear")
  `FLT_ASSERT_SAME(a_result_ok, out_valid && !div_error, common_div != '0 && is_whole == (denom_out == W'(1)), "bad reduced result")
  `FLT_ASSERT_NEXT(a_zero_denom, in_valid && !in_stall && denom_in == '0, out_valid && div_error, "zero denominator not flagged")

endmodule
